/* src/ptfr_pkg.sv */
package ptfr_pkg;

    // fixed field widths
    localparam int ADDR_W     = 16;
    localparam int OFFSET_W   = 8;
    localparam int VPAGE_W    = 8;
    localparam int FRAME_NO_W = 8;
    localparam int PHYS_W     = 15;
    localparam int FAULT_W    = 32;

    // default sizes
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 128;

    // virtual page number to table index, one entry per 8-bit page number
    typedef logic [(1 << VPAGE_W)-1:0][VPAGE_W-1:0] t_page_tab;

    // builds the page reduction table by counting, no divider needed
    function automatic t_page_tab f_page_tab(input int pages);
        t_page_tab tab;
        int        r;
        r = 0;
        for (int i = 0; i < (1 << VPAGE_W); i++) begin
            tab[i] = VPAGE_W'(r);
            r = r + 1;
            if (r == pages) begin
                r = 0;
            end
        end
        return tab;
    endfunction

endpackage

/* src/page_translation_fifo_replace_unit.sv */
// channel  | direction | valid        | stall        | word
// ---------+-----------+--------------+--------------+-------------------------------------
// input    | in        | i_in_valid   | o_in_stall   | i_virt_addr
// output   | out       | o_out_valid  | i_out_stall  | o_phys_addr, o_page_fault, o_evicted,
//          |           |              |              | o_evicted_page, o_fault_total
//
// On acceptance the page table memory and the frame owner memory are read; the
// lookup state then resolves hit, free frame or FIFO victim and, on a miss, writes
// both memories back. One word is in work at a time.
// Reset is synchronous: all page table entries become invalid through per-page
// valid flops, counters clear at once, no clearing pass.
// A new word is taken while a finished result still waits in the output register;
// the lookup holds its memory data until that register is free.
module page_translation_fifo_replace_unit
    import ptfr_pkg::*;
#(
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ADDR_W-1:0]   i_virt_addr,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PHYS_W-1:0]   o_phys_addr,
    output logic                o_page_fault,
    output logic                o_evicted,
    output logic [VPAGE_W-1:0]  o_evicted_page,
    output logic [FAULT_W-1:0]  o_fault_total
);

    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FU_W    = $clog2(FRAME_COUNT + 1);
    localparam t_page_tab PageTab = f_page_tab(PAGE_COUNT);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                r_state;
    logic [PAGE_COUNT-1:0] r_valid;
    logic [FU_W-1:0]       r_frames_used;
    logic [FRAME_W-1:0]    r_victim;
    logic [FAULT_W-1:0]    r_faults;
    logic [PAGE_W-1:0]     r_page;
    logic [OFFSET_W-1:0]   r_offset;
    logic                  r_hit;
    logic                  r_out_valid;
    logic [PHYS_W-1:0]     r_phys;
    logic                  r_fault;
    logic                  r_evicted;
    logic [VPAGE_W-1:0]    r_ev_page;

    logic                  in_accept;
    logic                  finish;
    logic                  full;
    logic                  evict;
    logic [PAGE_W-1:0]     page_idx;
    logic [FRAME_W-1:0]    pm_rdata;
    logic [PAGE_W-1:0]     owner_rdata;
    logic [FRAME_W-1:0]    n_frame;
    logic [FRAME_NO_W-1:0] frame8;
    logic [FAULT_W-1:0]    n_faults;
    logic [FRAME_W-1:0]    n_victim;
    logic [PAGE_COUNT-1:0] n_valid;

    // handshake
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign finish     = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);

    // page number reduced to the table range
    assign page_idx = PageTab[i_virt_addr[ADDR_W-1:OFFSET_W]][PAGE_W-1:0];

    // hit, free frame or fifo victim
    always_comb begin
        full     = (r_frames_used == FU_W'(FRAME_COUNT));
        evict    = !r_hit && full;
        if (r_hit) begin
            n_frame = pm_rdata;
        end else if (full) begin
            n_frame = r_victim;
        end else begin
            n_frame = r_frames_used[FRAME_W-1:0];
        end
        frame8   = FRAME_NO_W'(n_frame);
        n_faults = r_hit ? r_faults : r_faults + 1'b1;
        n_victim = (r_victim == FRAME_W'(FRAME_COUNT - 1)) ? '0 : r_victim + 1'b1;
    end

    // table valid bits after a fault: drop the evicted page, mark the new one
    always_comb begin
        n_valid = r_valid;
        if (evict) begin
            n_valid[owner_rdata] = 1'b0;
        end
        n_valid[r_page] = 1'b1;
    end

    // page table: frame number per page
    ptfr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_map (
        .i_clk   (i_clk),
        .i_we    (finish && !r_hit),
        .i_waddr (r_page),
        .i_wdata (n_frame),
        .i_re    (in_accept),
        .i_raddr (page_idx),
        .o_rdata (pm_rdata)
    );

    // page held by each frame
    ptfr_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (FRAME_COUNT)
    ) u_frame_owner (
        .i_clk   (i_clk),
        .i_we    (finish && !r_hit),
        .i_waddr (n_frame),
        .i_wdata (r_page),
        .i_re    (in_accept),
        .i_raddr (r_victim),
        .o_rdata (owner_rdata)
    );

    // state, table valid bits, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_frames_used <= '0;
            r_victim      <= '0;
            r_faults      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_page   <= page_idx;
                        r_offset <= i_virt_addr[OFFSET_W-1:0];
                        r_hit    <= r_valid[page_idx];
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (finish) begin
                        if (!r_hit) begin
                            if (evict) begin
                                r_victim <= n_victim;
                            end else begin
                                r_frames_used <= r_frames_used + 1'b1;
                            end
                            r_valid  <= n_valid;
                            r_faults <= n_faults;
                        end
                        r_phys      <= PHYS_W'({frame8, r_offset});
                        r_fault     <= !r_hit;
                        r_evicted   <= evict;
                        r_ev_page   <= evict ? VPAGE_W'(owner_rdata) : '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phys_addr    = r_phys;
    assign o_page_fault   = r_fault;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;
    assign o_fault_total  = r_faults;

    // a result only appears at the end of a lookup
    a_out_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_LOOK))
        else $error("result raised without a lookup");

    // fill count never passes the frame count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_used <= FU_W'(FRAME_COUNT))
        else $error("fill count beyond frame count");

    // an eviction is always part of a fault
    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_page_fault)
        else $error("eviction without fault");

    // victim pointer moves only once all frames are filled
    a_victim_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_victim != $past(r_victim) |-> $past(full))
        else $error("victim pointer moved before frames filled");

endmodule

/* src/ptfr_ram.sv */
module ptfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/tb_page_translation_fifo_replace_unit.sv */
module tb_page_translation_fifo_replace_unit;
    import ptfr_pkg::*;

    localparam int PAGES        = PAGE_COUNT_DEF;
    localparam int FRAMES       = FRAME_COUNT_DEF;
    localparam int RANDOM_WORDS = 1440;
    localparam int RECENT_DEPTH = 12;
    localparam int DRAIN_CYCLES = 12;

    // one translated word as the block reports it
    typedef struct packed {
        logic [PHYS_W-1:0]  phys_addr;
        logic               page_fault;
        logic               evicted;
        logic [VPAGE_W-1:0] evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } t_xlate;

    // directed row: address plus a hand-written result where it is obvious
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              known;
        t_xlate            want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 12;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // first word after reset takes frame 0
        '{16'h0000, 1'b1, '{15'h0000, 1'b1, 1'b0, 8'h00, 32'd1}},
        // top page, top offset into frame 1
        '{16'hFFFF, 1'b1, '{15'h01FF, 1'b1, 1'b0, 8'h00, 32'd2}},
        // hits on both extremes
        '{16'h00FF, 1'b1, '{15'h00FF, 1'b0, 1'b0, 8'h00, 32'd2}},
        '{16'hFF00, 1'b1, '{15'h0100, 1'b0, 1'b0, 8'h00, 32'd2}},
        // alternating bit patterns
        '{16'h5555, 1'b1, '{15'h0255, 1'b1, 1'b0, 8'h00, 32'd3}},
        '{16'hAAAA, 1'b1, '{15'h03AA, 1'b1, 1'b0, 8'h00, 32'd4}},
        '{16'h55AA, 1'b1, '{15'h02AA, 1'b0, 1'b0, 8'h00, 32'd4}},
        '{16'h8001, 1'b0, '0},
        '{16'h7FFE, 1'b0, '0},
        '{16'h0180, 1'b0, '0},
        '{16'h0001, 1'b0, '0},
        '{16'hAA55, 1'b0, '0}
    };

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [ADDR_W-1:0]   i_virt_addr    = '0;
    logic                i_out_stall    = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [PHYS_W-1:0]   o_phys_addr;
    logic                o_page_fault;
    logic                o_evicted;
    logic [VPAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0]  o_fault_total;

    // translator state kept by the testbench
    logic [FRAME_NO_W-1:0] pt_frame    [PAGES];
    bit                    pt_valid    [PAGES];
    logic [VPAGE_W-1:0]    frame_owner [FRAMES];
    int unsigned           frames_filled;
    int unsigned           victim_frame;
    logic [FAULT_W-1:0]    fault_count;

    t_xlate      pending_xlate_q [$];
    int unsigned send_idle_pct  = 23;
    int unsigned recv_stall_pct = 82;
    int          mismatches     = 0;
    int          words_seen     = 0;
    int          faults_seen    = 0;
    int          evictions_seen = 0;

    page_translation_fifo_replace_unit #(
        .PAGE_COUNT  (PAGES),
        .FRAME_COUNT (FRAMES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_virt_addr    (i_virt_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_phys_addr    (o_phys_addr),
        .o_page_fault   (o_page_fault),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page),
        .o_fault_total  (o_fault_total)
    );

    // clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // translate one address and update the page table, fifo replacement on a full set
    function automatic t_xlate translate_addr(input logic [ADDR_W-1:0] va);
        t_xlate      r;
        int unsigned pg;
        int unsigned frame;
        r  = '0;
        pg = int'(va[ADDR_W-1:OFFSET_W]) % PAGES;
        if (pt_valid[pg]) begin
            frame = pt_frame[pg];
        end else begin
            r.page_fault = 1'b1;
            if (frames_filled < FRAMES) begin
                frame = frames_filled;
                frames_filled++;
            end else begin
                frame          = victim_frame;
                r.evicted      = 1'b1;
                r.evicted_page = frame_owner[frame];
                pt_valid[frame_owner[frame]] = 1'b0;
                victim_frame   = (victim_frame + 1) % FRAMES;
            end
            frame_owner[frame] = VPAGE_W'(pg);
            pt_frame[pg]       = FRAME_NO_W'(frame);
            pt_valid[pg]       = 1'b1;
            fault_count++;
        end
        r.phys_addr   = PHYS_W'(frame * 256 + int'(va[OFFSET_W-1:0]));
        r.fault_total = fault_count;
        return r;
    endfunction

    // present one word, with a random gap first, and hold it until taken
    task automatic send_word(input logic [ADDR_W-1:0] va, input logic known,
                             input t_xlate want);
        t_xlate got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_virt_addr <= va;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        got = translate_addr(va);
        pending_xlate_q.push_back(known ? want : got);
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // random receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each taken result word against the oldest expectation
    always @(posedge i_clk) begin
        t_xlate want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (o_page_fault) faults_seen++;
            if (o_evicted) evictions_seen++;
            if (pending_xlate_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, phys_addr %0h",
                         $time, o_phys_addr);
            end else begin
                want = pending_xlate_q.pop_front();
                check_field("phys_addr", want.phys_addr, o_phys_addr);
                check_field("page_fault", want.page_fault, o_page_fault);
                check_field("evicted", want.evicted, o_evicted);
                check_field("evicted_page", want.evicted_page, o_evicted_page);
                check_field("fault_total", want.fault_total, o_fault_total);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [VPAGE_W-1:0] recent [RECENT_DEPTH];
        logic [ADDR_W-1:0]  va;
        int unsigned        pick;
        for (int p = 0; p < PAGES; p++) begin
            pt_valid[p] = 1'b0;
            pt_frame[p] = '0;
        end
        for (int f = 0; f < FRAMES; f++) begin
            frame_owner[f] = '0;
        end
        for (int k = 0; k < RECENT_DEPTH; k++) begin
            recent[k] = '0;
        end
        frames_filled = 0;
        victim_frame  = 0;
        fault_count   = '0;

        // hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_word(DIRECTED[r].addr, DIRECTED[r].known, DIRECTED[r].want);
        end

        // random words, biased toward recently touched pages to get hits
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                send_idle_pct  = 82;
                recv_stall_pct = 23;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                va = {recent[$urandom_range(RECENT_DEPTH - 1)], OFFSET_W'($urandom)};
            end else begin
                va = ADDR_W'($urandom);
            end
            recent[n % RECENT_DEPTH] = va[ADDR_W-1:OFFSET_W];
            send_word(va, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain, then watch for stray words
        while (pending_xlate_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words translated: %0d page faults, %0d fifo evictions",
                 words_seen, faults_seen, evictions_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("timeout with %0d words still expected", pending_xlate_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
src/ptfr_pkg.sv
src/ptfr_ram.sv
src/page_translation_fifo_replace_unit.sv
verif/tb_page_translation_fifo_replace_unit.sv
